FILE: hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// checked at every clock edge, reset included
`define ASSERT_NO_DISABLE(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/pdc_pkg.sv
// types, constants and the crc update function of the packet deframer
package pdc_pkg;

   localparam int unsigned DATA_W          = 8;
   localparam int unsigned CNT_W           = 9;
   localparam int unsigned HDR_BYTES       = 5;
   localparam int unsigned CRC_BYTES       = 4;
   localparam int unsigned MAX_PAYLOAD_DEF = 255;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;
   localparam int unsigned CSR_IDX_W       = 2;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;
   localparam logic [31:0]      CRC_POLY  = 32'hEDB8_8320;
   localparam logic [31:0]      CRC_INIT  = 32'hFFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_FIRST    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_SECOND   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT_VERSION = 2'd2;

   localparam logic RESULT_PAYLOAD = 1'b0;
   localparam logic RESULT_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_OK          = 3'd0,
      VERDICT_SHORT       = 3'd1,
      VERDICT_BAD_MAGIC   = 3'd2,
      VERDICT_BAD_VERSION = 3'd3,
      VERDICT_LENGTH      = 3'd4,
      VERDICT_CRC         = 3'd5
   } verdict_type;

   typedef struct packed {
      logic              result_kind;
      logic [DATA_W-1:0] payload_byte;
      logic [DATA_W-1:0] payload_offset;
      verdict_type       verdict;
      logic [DATA_W-1:0] message_type;
      logic [DATA_W-1:0] payload_length;
   } rsp_type;

   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/pdc_front.sv
// front end: config registers, header parsing, crc and result classification
module pdc_front #(
   parameter int unsigned MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [pdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdc_pkg::DATA_W-1:0]    csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [pdc_pkg::DATA_W-1:0]    req_data_byte,
   input  logic                         req_last_byte,
   input  logic                         queue_space,
   output logic                         push_valid,
   output pdc_pkg::rsp_type             push_item
);
   import pdc_pkg::*;

   localparam logic [DATA_W-1:0] MAX_LEN    = DATA_W'(MAX_PAYLOAD);
   localparam logic [CNT_W-1:0]  HDR_CNT    = CNT_W'(HDR_BYTES);
   localparam logic [CNT_W-1:0]  CRC_CNT    = CNT_W'(CRC_BYTES);
   localparam logic [CNT_W-1:0]  FRAME_MIN  = CNT_W'(HDR_BYTES + CRC_BYTES);

   logic [DATA_W-1:0] magic_first_ff, magic_second_ff, format_version_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              magic_bad_ff, magic_bad_in;
   logic              version_bad_ff, version_bad_in;
   logic [DATA_W-1:0] type_ff, type_in;
   logic [DATA_W-1:0] length_ff, length_in;
   logic [31:0]       crc_ff, crc_in;
   logic [31:0]       tail_ff, tail_in;
   logic              accept, emit;
   logic [CNT_W-1:0]  pos;
   verdict_type       verdict;

   assign req_ready = queue_space;
   assign accept    = req_valid && req_ready;
   assign pos       = count_ff - HDR_CNT;

   always_comb begin
      magic_bad_in   = magic_bad_ff;
      version_bad_in = version_bad_ff;
      type_in        = type_ff;
      length_in      = length_ff;
      if (count_ff == CNT_W'(0) && req_data_byte != magic_first_ff) begin
         magic_bad_in = 1'b1;
      end
      if (count_ff == CNT_W'(1) && req_data_byte != magic_second_ff) begin
         magic_bad_in = 1'b1;
      end
      if (count_ff == CNT_W'(2) && req_data_byte != format_version_ff) begin
         version_bad_in = 1'b1;
      end
      if (count_ff == CNT_W'(3)) begin
         type_in = req_data_byte;
      end
      if (count_ff == CNT_W'(4)) begin
         length_in = req_data_byte;
      end
      emit = (count_ff >= HDR_CNT) && (length_ff <= MAX_LEN) &&
             (pos < {1'b0, length_ff});
      crc_in = (count_ff >= CRC_CNT) ? crc_feed(crc_ff, tail_ff[7:0]) : crc_ff;
      tail_in = {req_data_byte, tail_ff[31:8]};
      count_in = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + CNT_W'(1);
   end

   always_comb begin
      if (count_in < FRAME_MIN) begin
         verdict = VERDICT_SHORT;
      end else if (magic_bad_in) begin
         verdict = VERDICT_BAD_MAGIC;
      end else if (version_bad_in) begin
         verdict = VERDICT_BAD_VERSION;
      end else if (length_in > MAX_LEN || count_in != FRAME_MIN + CNT_W'(length_in)) begin
         verdict = VERDICT_LENGTH;
      end else if ((crc_in ^ CRC_INIT) != tail_in) begin
         verdict = VERDICT_CRC;
      end else begin
         verdict = VERDICT_OK;
      end
   end

   always_comb begin
      push_valid               = accept && (req_last_byte || emit);
      push_item.message_type   = type_in;
      push_item.payload_length = length_in;
      if (req_last_byte) begin
         push_item.result_kind    = RESULT_VERDICT;
         push_item.payload_byte   = '0;
         push_item.payload_offset = '0;
         push_item.verdict        = verdict;
      end else begin
         push_item.result_kind    = RESULT_PAYLOAD;
         push_item.payload_byte   = req_data_byte;
         push_item.payload_offset = pos[DATA_W-1:0];
         push_item.verdict        = VERDICT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff    <= '0;
         magic_second_ff   <= '0;
         format_version_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAGIC_FIRST:    magic_first_ff    <= csr_write_data;
            CSR_MAGIC_SECOND:   magic_second_ff   <= csr_write_data;
            CSR_FORMAT_VERSION: format_version_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         count_ff       <= '0;
         magic_bad_ff   <= 1'b0;
         version_bad_ff <= 1'b0;
         type_ff        <= '0;
         length_ff      <= '0;
         crc_ff         <= CRC_INIT;
         tail_ff        <= '0;
      end else if (accept) begin
         count_ff       <= count_in;
         magic_bad_ff   <= magic_bad_in;
         version_bad_ff <= version_bad_in;
         type_ff        <= type_in;
         length_ff      <= length_in;
         crc_ff         <= crc_in;
         tail_ff        <= tail_in;
      end
   end

endmodule

FILE: hw/rtl/pdc_queue.sv
// small result queue between the front end and the output stage
module pdc_queue #(
   parameter int unsigned DEPTH = pdc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pdc_pkg::rsp_type push_item,
   output logic             space,
   output logic             head_valid,
   output pdc_pkg::rsp_type head_item,
   input  logic             pop
);
   import pdc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL     = FILL_W'(DEPTH);

   rsp_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, rd_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_pop;

   assign space      = fill_ff != FULL;
   assign head_valid = fill_ff != '0;
   assign head_item  = entry_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      fill_in = fill_ff;
      if (push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ff <= (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
         end
      end
   end

endmodule

FILE: hw/rtl/pdc_back.sv
// output stage: registered result handed to the receiver
module pdc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  pdc_pkg::rsp_type head_item,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pdc_pkg::rsp_type rsp_item
);
   import pdc_pkg::*;

   logic    valid_ff;
   rsp_type item_ff;

   assign pop       = head_valid && (!valid_ff || rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || rsp_ready) begin
         valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head_item;
      end
   end

endmodule

FILE: hw/rtl/packet_deframer_crc32_check_unit.sv
// top level of the length-prefixed packet deframer with crc-32 check
//
// req channel: one packet byte per item, req_last_byte marks the final byte.
// rsp channel: a payload item for each byte in a payload position (byte and
// offset), and one verdict item on the last byte, with message type and length.
// csr port: magic_first, magic_second and format_version, written by index
// only while the block is idle, as the user ensures; other indexes are ignored.
// throughput: one byte per cycle while the queue has space; the byte-wide crc
// update of the front end completes in the accepting cycle.
// result path: an accepted byte's result is written into the queue, then
// loaded into the output register once that register is empty or taken.
// receiver stall: results collect in the queue; req_ready drops once the
// queue is full and rises again as the receiver takes items.
// reset: config registers clear to zero, packet state returns to its start,
// queue and output stage are emptied.
module packet_deframer_crc32_check_unit #(
   parameter int unsigned MAX_PAYLOAD = pdc_pkg::MAX_PAYLOAD_DEF,
   parameter int unsigned QUEUE_DEPTH = pdc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [pdc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pdc_pkg::DATA_W-1:0]    csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pdc_pkg::DATA_W-1:0]    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_result_kind,
   output logic [pdc_pkg::DATA_W-1:0]    rsp_payload_byte,
   output logic [pdc_pkg::DATA_W-1:0]    rsp_payload_offset,
   output logic [2:0]                    rsp_verdict,
   output logic [pdc_pkg::DATA_W-1:0]    rsp_message_type,
   output logic [pdc_pkg::DATA_W-1:0]    rsp_payload_length
);
   import pdc_pkg::*;

   logic    queue_space, push_valid, head_valid, pop;
   rsp_type push_item, head_item, rsp_item;

   pdc_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .queue_space      (queue_space),
      .push_valid       (push_valid),
      .push_item        (push_item)
   );

   pdc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_item  (push_item),
      .space      (queue_space),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   pdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

   assign rsp_result_kind    = rsp_item.result_kind;
   assign rsp_payload_byte   = rsp_item.payload_byte;
   assign rsp_payload_offset = rsp_item.payload_offset;
   assign rsp_verdict        = rsp_item.verdict;
   assign rsp_message_type   = rsp_item.message_type;
   assign rsp_payload_length = rsp_item.payload_length;

endmodule

FILE: hw/rtl/pdc_checker.sv
// port-level checker for the packet deframer, bound to the top level
`include "assert_macros.svh"

module pdc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_result_kind,
   input logic [pdc_pkg::DATA_W-1:0]    rsp_payload_byte,
   input logic [pdc_pkg::DATA_W-1:0]    rsp_payload_offset,
   input logic [2:0]                    rsp_verdict
);
   import pdc_pkg::*;

   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_payload_byte) && $stable(rsp_payload_offset) && $stable(rsp_verdict))
   `ASSERT_ALWAYS(a_verdict_clean, clock, reset, !(rsp_valid && rsp_result_kind == RESULT_VERDICT) || (rsp_payload_byte == '0 && rsp_payload_offset == '0))
   `ASSERT_ALWAYS(a_payload_clean, clock, reset, !(rsp_valid && rsp_result_kind == RESULT_PAYLOAD) || (rsp_verdict == VERDICT_OK))
   `ASSERT_NO_DISABLE(a_reset_empty, clock, $past(reset), !rsp_valid)

endmodule

bind packet_deframer_crc32_check_unit pdc_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_payload_offset (rsp_payload_offset),
   .rsp_verdict        (rsp_verdict)
);
